### hdl/sorted_priority_queue_assert.svh
// Assertion macros for the sorted priority queue.
// Included by files that check their own logic; no other dependencies.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SPQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
// No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_DEQUEUED = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [15:0] key;
        logic [7:0]  vertex_tag;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_key;
        logic [7:0]  out_tag;
        logic [4:0]  occupancy;
    } t_out_item;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_cmd;

endpackage

### hdl/spq_cells.sv
// Datapath of the sorted priority queue: a row of key/tag cells kept in
// ascending key order. Uses spq_pkg.
`timescale 1ns / 1ps

module spq_cells #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_WIDTH   = 16,
    parameter int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                  i_clk,
    input  spq_pkg::t_cell_cmd    i_cmd,
    input  logic [CNT_WIDTH-1:0]  i_count,
    input  logic [KEY_WIDTH-1:0]  i_key,
    input  logic [7:0]            i_tag,
    output logic [KEY_WIDTH-1:0]  o_head_key,
    output logic [7:0]            o_head_tag
);

    logic [KEY_WIDTH-1:0] r_key [QUEUE_DEPTH];
    logic [7:0]           r_tag [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] w_le;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            logic [KEY_WIDTH-1:0] n_key;
            logic [7:0]           n_tag;
            logic                 w_take_new;

            // cell stays put when it holds a key not above the new one
            assign w_le[gi] = (CNT_WIDTH'(gi) < i_count) && (r_key[gi] <= i_key);

            if (gi == 0) begin : g_first
                assign w_take_new = 1'b1;
            end else begin : g_rest
                assign w_take_new = w_le[gi-1];
            end

            always_comb begin
                n_key = r_key[gi];
                n_tag = r_tag[gi];
                if (i_cmd.push && !w_le[gi]) begin
                    if (w_take_new) begin
                        n_key = i_key;
                        n_tag = i_tag;
                    end else begin
                        n_key = r_key[gi-1 < 0 ? 0 : gi-1];
                        n_tag = r_tag[gi-1 < 0 ? 0 : gi-1];
                    end
                end else if (i_cmd.pop) begin
                    n_key = r_key[gi+1 >= QUEUE_DEPTH ? gi : gi+1];
                    n_tag = r_tag[gi+1 >= QUEUE_DEPTH ? gi : gi+1];
                end
            end

            always_ff @(posedge i_clk) begin
                r_key[gi] <= n_key;
                r_tag[gi] <= n_tag;
            end
        end
    endgenerate

    assign o_head_key = r_key[0];
    assign o_head_tag = r_tag[0];

endmodule

### hdl/spq_ctrl.sv
// Controller of the sorted priority queue: handshakes, entry count,
// result register and cell commands. Uses spq_pkg.
`timescale 1ns / 1ps

module spq_ctrl #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_WIDTH   = 16,
    parameter int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  spq_pkg::t_in_item     i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output spq_pkg::t_out_item    o_out_item,
    output spq_pkg::t_cell_cmd    o_cmd,
    output logic [CNT_WIDTH-1:0]  o_count,
    output logic [KEY_WIDTH-1:0]  o_key,
    output logic [7:0]            o_tag,
    input  logic [KEY_WIDTH-1:0]  i_head_key,
    input  logic [7:0]            i_head_tag
);

    logic                 r_out_valid;
    logic                 n_out_valid;
    spq_pkg::t_out_item   r_out_item;
    spq_pkg::t_out_item   n_out_item;
    logic [CNT_WIDTH-1:0] r_count;
    logic [CNT_WIDTH-1:0] n_count;
    logic                 w_accept;
    logic                 w_full;
    logic                 w_empty;
    logic [63:0]          w_in_key64;
    logic [63:0]          w_head_key64;
    logic [31:0]          w_occ32;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_full      = (r_count == CNT_WIDTH'(QUEUE_DEPTH));
    assign w_empty     = (r_count == '0);

    assign w_in_key64   = 64'(i_in_item.key);
    assign w_head_key64 = 64'(i_head_key);
    assign w_occ32      = 32'(n_count);

    assign o_key   = w_in_key64[KEY_WIDTH-1:0];
    assign o_tag   = i_in_item.vertex_tag;
    assign o_count = r_count;

    always_comb begin
        o_cmd      = '0;
        n_count    = r_count;
        n_out_item = r_out_item;
        if (w_accept) begin
            n_out_item.out_key = '0;
            n_out_item.out_tag = '0;
            if (i_in_item.operation == spq_pkg::OP_ENQUEUE) begin
                if (w_full) begin
                    n_out_item.status = spq_pkg::ST_FULL;
                end else begin
                    o_cmd.push        = 1'b1;
                    n_count           = r_count + 1'b1;
                    n_out_item.status = spq_pkg::ST_ENQUEUED;
                end
            end else begin
                if (w_empty) begin
                    n_out_item.status = spq_pkg::ST_EMPTY;
                end else begin
                    o_cmd.pop          = 1'b1;
                    n_count            = r_count - 1'b1;
                    n_out_item.status  = spq_pkg::ST_DEQUEUED;
                    n_out_item.out_key = w_head_key64[15:0];
                    n_out_item.out_tag = i_head_tag;
                end
            end
            n_out_item.occupancy = w_occ32[4:0];
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue: controller plus cell row.
// Uses spq_pkg, spq_ctrl, spq_cells and sorted_priority_queue_assert.svh.
//
//   channel   direction   handshake                 payload
//   in        to block    i_in_valid / o_in_ready   i_in_item  (spq_pkg::t_in_item)
//   out       from block  o_out_valid / i_out_ready o_out_item (spq_pkg::t_out_item)
//
// One item per cycle while no result waits on a stalled output; its result appears in the cycle after the transfer.
// All cells compare against the new key at once, so insert or removal ends in that cycle.
// Synchronous active-low reset empties the queue; no clearing pass.
// The input stalls only while a result waits and the output is not ready.
`timescale 1ns / 1ps
`include "sorted_priority_queue_assert.svh"

module sorted_priority_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_WIDTH   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  spq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output spq_pkg::t_out_item o_out_item
);

    localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

    spq_pkg::t_cell_cmd   w_cmd;
    logic [CNT_WIDTH-1:0] w_count;
    logic [KEY_WIDTH-1:0] w_key;
    logic [7:0]           w_tag;
    logic [KEY_WIDTH-1:0] w_head_key;
    logic [7:0]           w_head_tag;

    spq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .CNT_WIDTH   (CNT_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .o_cmd       (w_cmd),
        .o_count     (w_count),
        .o_key       (w_key),
        .o_tag       (w_tag),
        .i_head_key  (w_head_key),
        .i_head_tag  (w_head_tag)
    );

    spq_cells #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .CNT_WIDTH   (CNT_WIDTH)
    ) u_cells (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_count    (w_count),
        .i_key      (w_key),
        .i_tag      (w_tag),
        .o_head_key (w_head_key),
        .o_head_tag (w_head_tag)
    );

    `SPQ_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, w_count <= CNT_WIDTH'(QUEUE_DEPTH))
    `SPQ_ASSERT_NEXT(a_push_counts, i_clk, i_rst_n, w_cmd.push && !w_cmd.pop, w_count == $past(w_count) + 1'b1)
    `SPQ_ASSERT_IMPLY(a_empty_occ, i_clk, i_rst_n, o_out_valid && (o_out_item.status == spq_pkg::ST_EMPTY), o_out_item.occupancy == 5'd0)

endmodule

### sim/spq_checker.sv
// Scoreboard for the sorted priority queue: watches both channels, keeps its own
// sorted copy of the queue and compares every result transfer. Uses spq_pkg.
`timescale 1ns / 1ps

module spq_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  spq_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  spq_pkg::t_out_item i_out_item,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_dequeued,
    output int                 o_empty_hits,
    output int                 o_full_hits
);

    logic [15:0]        held_keys [QUEUE_DEPTH];
    logic [7:0]         held_tags [QUEUE_DEPTH];
    int                 held;
    spq_pkg::t_out_item awaited_results [$];
    int                 fails;
    int                 dequeued;
    int                 empty_hits;
    int                 full_hits;

    // Insert after every entry with key <= new key; remove from the head.
    function automatic spq_pkg::t_out_item apply_queue_op(input spq_pkg::t_in_item item);
        spq_pkg::t_out_item res;
        int                 pos;
        res = '0;
        if (item.operation == spq_pkg::OP_ENQUEUE) begin
            if (held >= QUEUE_DEPTH) begin
                res.status = spq_pkg::ST_FULL;
            end else begin
                pos = 0;
                while (pos < held && held_keys[pos] <= item.key) pos++;
                for (int i = held; i > pos; i--) begin
                    held_keys[i] = held_keys[i - 1];
                    held_tags[i] = held_tags[i - 1];
                end
                held_keys[pos] = item.key;
                held_tags[pos] = item.vertex_tag;
                held++;
                res.status = spq_pkg::ST_ENQUEUED;
            end
        end else begin
            if (held == 0) begin
                res.status = spq_pkg::ST_EMPTY;
            end else begin
                res.out_key = held_keys[0];
                res.out_tag = held_tags[0];
                for (int i = 1; i < held; i++) begin
                    held_keys[i - 1] = held_keys[i];
                    held_tags[i - 1] = held_tags[i];
                end
                held--;
                res.status = spq_pkg::ST_DEQUEUED;
            end
        end
        res.occupancy = 5'(held);
        return res;
    endfunction

    always @(posedge i_clk) begin
        spq_pkg::t_out_item want;
        spq_pkg::t_out_item got;
        if (!i_rst_n) begin
            held = 0;
            awaited_results.delete();
            fails      = 0;
            dequeued   = 0;
            empty_hits = 0;
            full_hits  = 0;
        end else begin
            // compare first so a result never matches an item taken at this same edge
            if (i_out_valid && i_out_ready) begin
                got = i_out_item;
                if (awaited_results.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result status=%0d key=%h tag=%h occ=%0d",
                             $time, got.status, got.out_key, got.out_tag, got.occupancy);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status || got.out_key !== want.out_key ||
                        got.out_tag !== want.out_tag || got.occupancy !== want.occupancy) begin
                        fails++;
                        $display({"%0t: mismatch expected status=%0d key=%h tag=%h occ=%0d",
                                  " got status=%0d key=%h tag=%h occ=%0d"}, $time,
                                 want.status, want.out_key, want.out_tag, want.occupancy,
                                 got.status, got.out_key, got.out_tag, got.occupancy);
                    end
                    case (want.status)
                        spq_pkg::ST_DEQUEUED: dequeued++;
                        spq_pkg::ST_EMPTY:    empty_hits++;
                        spq_pkg::ST_FULL:     full_hits++;
                        default: ;
                    endcase
                end
            end
            if (i_in_valid && i_in_ready)
                awaited_results.push_back(apply_queue_op(i_in_item));
        end
        o_fail_count <= fails;
        o_pending    <= awaited_results.size();
        o_dequeued   <= dequeued;
        o_empty_hits <= empty_hits;
        o_full_hits  <= full_hits;
    end

endmodule

### sim/tb.sv
// Testbench top for sorted_priority_queue: clock, reset, directed and random
// enqueue/dequeue traffic under several idle/stall mixes. Uses spq_pkg, spq_checker.
`timescale 1ns / 1ps

module tb;

    localparam int QUEUE_DEPTH    = 16;
    localparam int RANDOM_PER_MIX = 444;
    localparam int WATCHDOG_LIMIT = 2000;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    spq_pkg::t_in_item  in_item   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    spq_pkg::t_out_item out_item;

    int fail_count;
    int pending;
    int dequeued;
    int empty_hits;
    int full_hits;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int sent           = 0;
    int quiet_cycles   = 0;

    sorted_priority_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_WIDTH   (16)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    spq_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_dequeued   (dequeued),
        .o_empty_hits (empty_hits),
        .o_full_hits  (full_hits)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
        $display("tb failed");
        $finish;
    end

    task automatic send_entry(input logic op, input logic [15:0] key, input logic [7:0] tag);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{operation: op, key: key, vertex_tag: tag};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    // hold the input off until every outstanding result has transferred
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [15:0] pick_key();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 7));
            1: case ($urandom_range(0, 3))
                   0: return 16'h0000;
                   1: return 16'hFFFF;
                   2: return 16'h8000;
                   default: return 16'h7FFF;
               endcase
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_traffic(input int count);
        int enq_pct;
        int burst;
        enq_pct = 50;
        burst   = 0;
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                burst = $urandom_range(10, 60);
                case ($urandom_range(0, 3))
                    0: enq_pct = 10;
                    1: enq_pct = 45;
                    2: enq_pct = 55;
                    default: enq_pct = 90;
                endcase
            end
            burst--;
            send_entry(($urandom_range(0, 99) < enq_pct) ? spq_pkg::OP_ENQUEUE
                                                         : spq_pkg::OP_DEQUEUE,
                       pick_key(), 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty dequeue, key/tag extremes, equal keys, fill to full and overflow
        send_entry(spq_pkg::OP_DEQUEUE, 16'h0000, 8'hFF);
        send_entry(spq_pkg::OP_ENQUEUE, 16'hFFFF, 8'hFF);
        send_entry(spq_pkg::OP_ENQUEUE, 16'h0000, 8'h00);
        send_entry(spq_pkg::OP_ENQUEUE, 16'h0000, 8'hFF);
        send_entry(spq_pkg::OP_ENQUEUE, 16'h0000, 8'h5A);
        send_entry(spq_pkg::OP_ENQUEUE, 16'h8000, 8'hA5);
        send_entry(spq_pkg::OP_ENQUEUE, 16'h7FFF, 8'h01);
        send_entry(spq_pkg::OP_ENQUEUE, 16'hFFFF, 8'h00);
        send_entry(spq_pkg::OP_ENQUEUE, 16'h5555, 8'h80);
        send_entry(spq_pkg::OP_ENQUEUE, 16'hAAAA, 8'h7F);
        send_entry(spq_pkg::OP_ENQUEUE, 16'h0001, 8'h33);
        send_entry(spq_pkg::OP_ENQUEUE, 16'h0001, 8'hCC);
        send_entry(spq_pkg::OP_ENQUEUE, 16'h1234, 8'h12);
        send_entry(spq_pkg::OP_ENQUEUE, 16'hFFFE, 8'hFE);
        send_entry(spq_pkg::OP_ENQUEUE, 16'h00FF, 8'h0F);
        send_entry(spq_pkg::OP_ENQUEUE, 16'hFF00, 8'hF0);
        send_entry(spq_pkg::OP_ENQUEUE, 16'h8000, 8'h5A);
        send_entry(spq_pkg::OP_ENQUEUE, 16'h0000, 8'h77);
        for (int d = 0; d < 6; d++) send_entry(spq_pkg::OP_DEQUEUE, 16'hFFFF, 8'hFF);

        random_traffic(RANDOM_PER_MIX);
        drain_results();
        send_idle_pct  = 54;
        recv_stall_pct = 0;
        random_traffic(RANDOM_PER_MIX);
        drain_results();
        send_idle_pct  = 0;
        recv_stall_pct = 54;
        random_traffic(RANDOM_PER_MIX);
        drain_results();
        send_idle_pct  = 32;
        recv_stall_pct = 32;
        random_traffic(RANDOM_PER_MIX);

        drain_results();
        repeat (5) @(posedge clk);

        $display("Sent %0d items: %0d dequeued entries, %0d empty dequeues, %0d full drops,",
                 sent, dequeued, empty_hits, full_hits);
        $display("across free-running, sender-idle, receiver-stall and mixed phases.");
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
